// ===== design/iows_pkg.sv =====
`default_nettype none
package iows_pkg;

  localparam int SAMPLE_DEPTH = 64;
  localparam int SLOT_W       = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);
  localparam int NBUCKET      = 6;
  localparam int DIV_STEPS    = 48;
  localparam int STEP_W       = $clog2(DIV_STEPS + 1);

  localparam logic [31:0] LIM_512  = 32'd512;
  localparam logic [31:0] LIM_1024 = 32'd1024;
  localparam logic [31:0] LIM_2048 = 32'd2048;
  localparam logic [31:0] LIM_4096 = 32'd4096;
  localparam logic [31:0] LIM_8192 = 32'd8192;

  typedef enum logic [1:0] {
    KIND_COMPLETE = 2'd0,
    KIND_TICK     = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TWR,
    ST_QRD,
    ST_QACC,
    ST_QOUT
  } state_e;

  typedef struct packed {
    logic [47:0]                   bytes;
    logic [31:0]                   lat_max;
    logic [31:0]                   lat_avg;
    logic [NBUCKET-1:0][31:0]      buckets;
  } sample_t;

  function automatic logic [2:0] bucket_of(logic [31:0] b);
    logic [2:0] k;
    if (b <= LIM_512)       k = 3'd0;
    else if (b <= LIM_1024) k = 3'd1;
    else if (b <= LIM_2048) k = 3'd2;
    else if (b <= LIM_4096) k = 3'd3;
    else if (b <= LIM_8192) k = 3'd4;
    else                    k = 3'd5;
    return k;
  endfunction

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [55:0] sat_add56(logic [55:0] a, logic [47:0] b);
    logic [56:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[56] ? '1 : s[55:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/io_window_statistics_core.sv =====
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | kind, io_bytes, latency_ms, window
// out     | output    | out_valid_o/out_stall_i | samples_used, sums, peak, buckets
//
// completion and clear leave the core idle; a tick on an idle interval goes straight to the ring write,
// otherwise it first waits for the one-bit-a-cycle 48-bit divider for the average
// a query does one ring read and one accumulate per sample, then loads the result
// the ring is a single-port-read memory; after a clear its contents are never read
// reset clears accumulators, ring pointer, fill count and the output valid
// a query waits in its last step while the previous result is still stalled
module io_window_statistics_core import iows_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] io_bytes_i,
  input  wire logic [31:0] latency_ms_i,
  input  wire logic [6:0]  window_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       samples_used_o,
  output logic [55:0]      bytes_sum_o,
  output logic [55:0]      lat_avg_sum_o,
  output logic [31:0]      lat_max_peak_o,
  output logic [55:0]      count_upto_512_o,
  output logic [55:0]      count_upto_1024_o,
  output logic [55:0]      count_upto_2048_o,
  output logic [55:0]      count_upto_4096_o,
  output logic [55:0]      count_upto_8192_o,
  output logic [55:0]      count_over_8192_o
);

  state_e state_q, state_d;

  logic [47:0]              acc_bytes_q;
  logic [47:0]              acc_lat_sum_q;
  logic [31:0]              acc_lat_max_q;
  logic [31:0]              acc_ops_q;
  logic [NBUCKET-1:0][31:0] acc_bkt_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [CNT_W-1:0]         filled_q;
  logic [31:0]              avg_q;

  logic [SLOT_W-1:0]        idx_q, idx_prev;
  logic [CNT_W-1:0]         n_q, n_sel;
  logic [55:0]              bsum_q, asum_q;
  logic [31:0]              peak_q;
  logic [NBUCKET-1:0][55:0] bk_q;

  sample_t                  ring_mem [SAMPLE_DEPTH];
  sample_t                  rd_q;
  sample_t                  wr_data;

  logic        in_acc, out_free, out_load, div_start, div_done, mem_we, mem_re;
  logic [47:0] div_quo;
  kind_e       kind;
  logic [2:0]  bkt;

  assign kind     = kind_e'(kind_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign bkt      = bucket_of(io_bytes_i);
  assign idx_prev = (idx_q == '0) ? SLOT_W'(SAMPLE_DEPTH - 1) : idx_q - 1'b1;

  always_comb begin
    if (window_i == '0 || 32'(window_i) > 32'(SAMPLE_DEPTH)) n_sel = CNT_W'(SAMPLE_DEPTH);
    else                                                     n_sel = CNT_W'(window_i);
    if (n_sel > filled_q) n_sel = filled_q;
  end

  iows_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_lat_sum_q),
    .divisor_i  (acc_ops_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind)
            KIND_TICK:  state_d = (acc_ops_q != '0) ? ST_DIV : ST_TWR;
            KIND_QUERY: state_d = (n_sel != '0) ? ST_QRD : ST_QOUT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV:  if (div_done) state_d = ST_TWR;
      ST_TWR:  state_d = ST_IDLE;
      ST_QRD:  state_d = ST_QACC;
      ST_QACC: state_d = (n_q == CNT_W'(1)) ? ST_QOUT : ST_QRD;
      ST_QOUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_acc && kind == KIND_TICK && acc_ops_q != '0;
      end
      ST_TWR:  mem_we = 1'b1;
      ST_QRD:  mem_re = 1'b1;
      ST_QOUT: out_load = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // interval accumulators and ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_bytes_q   <= '0;
      acc_lat_sum_q <= '0;
      acc_lat_max_q <= '0;
      acc_ops_q     <= '0;
      acc_bkt_q     <= '0;
      slot_q        <= '0;
      filled_q      <= '0;
    end else if (in_acc && kind == KIND_COMPLETE) begin
      acc_bytes_q   <= sat_add48(acc_bytes_q, io_bytes_i);
      acc_lat_sum_q <= sat_add48(acc_lat_sum_q, latency_ms_i);
      if (latency_ms_i > acc_lat_max_q) acc_lat_max_q <= latency_ms_i;
      if (acc_ops_q != '1) acc_ops_q <= acc_ops_q + 1'b1;
      if (acc_bkt_q[bkt] != '1) acc_bkt_q[bkt] <= acc_bkt_q[bkt] + 1'b1;
    end else if ((in_acc && kind == KIND_CLEAR) || mem_we) begin
      acc_bytes_q   <= '0;
      acc_lat_sum_q <= '0;
      acc_lat_max_q <= '0;
      acc_ops_q     <= '0;
      acc_bkt_q     <= '0;
      if (mem_we) begin
        slot_q <= (slot_q == SLOT_W'(SAMPLE_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        if (filled_q != CNT_W'(SAMPLE_DEPTH)) filled_q <= filled_q + 1'b1;
      end else begin
        slot_q   <= '0;
        filled_q <= '0;
      end
    end
  end

  // average, saturated to 32 bits; idle interval keeps zero
  always_ff @(posedge clk_i) begin
    if (in_acc && kind == KIND_TICK) avg_q <= '0;
    else if (div_done) avg_q <= (div_quo[47:32] != '0) ? '1 : div_quo[31:0];
  end

  assign wr_data = '{bytes: acc_bytes_q, lat_max: acc_lat_max_q, lat_avg: avg_q,
                     buckets: acc_bkt_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[slot_q] <= wr_data;
    if (mem_re) rd_q <= ring_mem[idx_prev];
  end

  // query walk, newest sample first
  always_ff @(posedge clk_i) begin
    if (in_acc && kind == KIND_QUERY) begin
      idx_q  <= slot_q;
      n_q    <= n_sel;
      bsum_q <= '0;
      asum_q <= '0;
      peak_q <= '0;
      bk_q   <= '0;
    end else if (state_q == ST_QRD) begin
      idx_q <= idx_prev;
    end else if (state_q == ST_QACC) begin
      n_q    <= n_q - 1'b1;
      bsum_q <= sat_add56(bsum_q, rd_q.bytes);
      asum_q <= sat_add56(asum_q, {16'd0, rd_q.lat_avg});
      if (rd_q.lat_max > peak_q) peak_q <= rd_q.lat_max;
      for (int k = 0; k < NBUCKET; k++) begin
        bk_q[k] <= sat_add56(bk_q[k], {16'd0, rd_q.buckets[k]});
      end
    end
  end

  logic [CNT_W-1:0] used_q;
  always_ff @(posedge clk_i) begin
    if (in_acc && kind == KIND_QUERY) used_q <= n_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       out_valid_o <= 1'b0;
    else if (out_load) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      samples_used_o    <= 7'(used_q);
      bytes_sum_o       <= bsum_q;
      lat_avg_sum_o     <= asum_q;
      lat_max_peak_o    <= peak_q;
      count_upto_512_o  <= bk_q[0];
      count_upto_1024_o <= bk_q[1];
      count_upto_2048_o <= bk_q[2];
      count_upto_4096_o <= bk_q[3];
      count_upto_8192_o <= bk_q[4];
      count_over_8192_o <= bk_q[5];
    end
  end

endmodule
`default_nettype wire

// ===== design/iows_div.sv =====
`default_nettype none
module iows_div import iows_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [47:0]      quotient_o
);

  logic [47:0]       quo_q;
  logic [31:0]       rem_q;
  logic [31:0]       dvs_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [32:0]       trial;
  logic              fits;

  // one restoring step per cycle, dividend shifts out as quotient shifts in
  assign trial = {rem_q, quo_q[47]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quo_q <= {quo_q[46:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== design/iows_checker.sv =====
`default_nettype none
module iows_checker import iows_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  kind_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [6:0]  samples_used_o,
  input wire logic [55:0] bytes_sum_o,
  input wire logic [55:0] lat_avg_sum_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bytes_sum_o))
    else $error("stalled result dropped or changed");

  // completions are taken back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == KIND_COMPLETE |=> !in_stall_o)
    else $error("completion stalled the input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(samples_used_o) <= 32'(SAMPLE_DEPTH))
    else $error("more samples than the ring holds");

  // an empty window sums to nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && samples_used_o == '0 |-> bytes_sum_o == '0 && lat_avg_sum_o == '0)
    else $error("empty window with non-zero sums");

endmodule

bind io_window_statistics_core iows_checker u_iows_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .kind_i         (kind_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .samples_used_o (samples_used_o),
  .bytes_sum_o    (bytes_sum_o),
  .lat_avg_sum_o  (lat_avg_sum_o)
);
`default_nettype wire

// ===== tb/tb_io_window_statistics_core.sv =====
`default_nettype none
module tb_io_window_statistics_core;
  import iows_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 650;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [6:0]               used;
    logic [55:0]              bytes;
    logic [55:0]              avg_sum;
    logic [31:0]              peak;
    logic [NBUCKET-1:0][55:0] counts;
  } window_sum_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] nbytes;
    logic [31:0] lat;
    logic [6:0]  win;
    logic        known;
    window_sum_t sum;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = KIND_COMPLETE;
  logic [31:0] io_bytes_i = '0;
  logic [31:0] latency_ms_i = '0;
  logic [6:0] window_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [6:0] samples_used_o;
  logic [55:0] bytes_sum_o, lat_avg_sum_o;
  logic [31:0] lat_max_peak_o;
  logic [55:0] count_upto_512_o, count_upto_1024_o, count_upto_2048_o;
  logic [55:0] count_upto_4096_o, count_upto_8192_o, count_over_8192_o;

  io_window_statistics_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [47:0] iv_bytes, iv_lat_sum;
  logic [31:0] iv_lat_max, iv_ops;
  logic [31:0] iv_buckets [NBUCKET];
  logic [SLOT_W-1:0] next_slot;
  int unsigned n_samples;
  logic [47:0] hist_bytes [SAMPLE_DEPTH];
  logic [31:0] hist_max [SAMPLE_DEPTH];
  logic [31:0] hist_avg [SAMPLE_DEPTH];
  logic [31:0] hist_buckets [SAMPLE_DEPTH][NBUCKET];

  window_sum_t pending_sums[$];
  int errors = 0;
  int idle_cycles = 0;
  logic timed_out = 1'b0;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    if (a >= lim || b >= lim - a) return lim;
    return a + b;
  endfunction

  function automatic int size_class(logic [31:0] b);
    if (b <= 512) return 0;
    if (b <= 1024) return 1;
    if (b <= 2048) return 2;
    if (b <= 4096) return 3;
    if (b <= 8192) return 4;
    return 5;
  endfunction

  task automatic zero_interval();
    iv_bytes = '0; iv_lat_sum = '0; iv_lat_max = '0; iv_ops = '0;
    for (int k = 0; k < NBUCKET; k++) iv_buckets[k] = '0;
  endtask

  task automatic wipe_history();
    zero_interval();
    next_slot = '0;
    n_samples = 0;
  endtask

  task automatic predict_item(input kind_e kind, input logic [31:0] nbytes,
                              input logic [31:0] lat, input logic [6:0] win);
    int c;
    logic [63:0] avg, bs, as, pk;
    logic [63:0] cnt [NBUCKET];
    int unsigned n;
    int idx;
    window_sum_t r;
    case (kind)
      KIND_COMPLETE: begin
        c = size_class(nbytes);
        iv_bytes = 48'(sat_sum(iv_bytes, nbytes, 64'hFFFF_FFFF_FFFF));
        iv_lat_sum = 48'(sat_sum(iv_lat_sum, lat, 64'hFFFF_FFFF_FFFF));
        if (lat > iv_lat_max) iv_lat_max = lat;
        iv_ops = 32'(sat_sum(iv_ops, 1, 64'hFFFF_FFFF));
        iv_buckets[c] = 32'(sat_sum(iv_buckets[c], 1, 64'hFFFF_FFFF));
      end
      KIND_TICK: begin
        avg = (iv_ops != 0) ? {16'd0, iv_lat_sum} / {32'd0, iv_ops} : 64'd0;
        if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
        hist_bytes[next_slot] = iv_bytes;
        hist_max[next_slot] = iv_lat_max;
        hist_avg[next_slot] = avg[31:0];
        for (int k = 0; k < NBUCKET; k++) hist_buckets[next_slot][k] = iv_buckets[k];
        next_slot = next_slot + 1'b1;
        if (n_samples < SAMPLE_DEPTH) n_samples++;
        zero_interval();
      end
      KIND_QUERY: begin
        n = win;
        if (n == 0 || n > SAMPLE_DEPTH) n = SAMPLE_DEPTH;
        if (n > n_samples) n = n_samples;
        bs = 0; as = 0; pk = 0;
        for (int k = 0; k < NBUCKET; k++) cnt[k] = 0;
        idx = next_slot;
        for (int i = 0; i < n; i++) begin
          idx = (idx + SAMPLE_DEPTH - 1) % SAMPLE_DEPTH;
          bs = sat_sum(bs, hist_bytes[idx], 64'hFF_FFFF_FFFF_FFFF);
          as = sat_sum(as, hist_avg[idx], 64'hFF_FFFF_FFFF_FFFF);
          if (hist_max[idx] > pk) pk = hist_max[idx];
          for (int k = 0; k < NBUCKET; k++)
            cnt[k] = sat_sum(cnt[k], hist_buckets[idx][k], 64'hFF_FFFF_FFFF_FFFF);
        end
        r.used = n[6:0];
        r.bytes = bs[55:0];
        r.avg_sum = as[55:0];
        r.peak = pk[31:0];
        for (int k = 0; k < NBUCKET; k++) r.counts[k] = cnt[k][55:0];
        pending_sums.push_back(r);
      end
      default: wipe_history();
    endcase
  endtask

  // one item through the input channel, with a random gap first
  task automatic send_item(input kind_e kind, input logic [31:0] nbytes,
                           input logic [31:0] lat, input logic [6:0] win);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if ($urandom_range(0, 1) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    io_bytes_i <= nbytes;
    latency_ms_i <= lat;
    window_i <= win;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(kind, nbytes, lat, win);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sums.size() != 0 && !timed_out) @(posedge clk_i);
  endtask

  // result check
  always @(posedge clk_i) begin
    window_sum_t e;
    logic [55:0] got [NBUCKET];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got[0] = count_upto_512_o;  got[1] = count_upto_1024_o;
      got[2] = count_upto_2048_o; got[3] = count_upto_4096_o;
      got[4] = count_upto_8192_o; got[5] = count_over_8192_o;
      if (pending_sums.size() == 0) begin
        $error("unexpected result, samples_used %0d", samples_used_o);
        errors++;
      end else begin
        e = pending_sums.pop_front();
        if (samples_used_o !== e.used) begin
          $error("samples_used: expected %0d, got %0d", e.used, samples_used_o);
          errors++;
        end
        if (bytes_sum_o !== e.bytes) begin
          $error("bytes_sum: expected %0d, got %0d", e.bytes, bytes_sum_o);
          errors++;
        end
        if (lat_avg_sum_o !== e.avg_sum) begin
          $error("lat_avg_sum: expected %0d, got %0d", e.avg_sum, lat_avg_sum_o);
          errors++;
        end
        if (lat_max_peak_o !== e.peak) begin
          $error("lat_max_peak: expected %0d, got %0d", e.peak, lat_max_peak_o);
          errors++;
        end
        for (int k = 0; k < NBUCKET; k++)
          if (got[k] !== e.counts[k]) begin
            $error("bucket %0d count: expected %0d, got %0d", k, e.counts[k], got[k]);
            errors++;
          end
      end
    end
  end

  // receiver stalls: a random count of stalled cycles per result
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  stim_row_t directed [$];

  function automatic stim_row_t row(kind_e kd, logic [31:0] b, logic [31:0] l,
                                    logic [6:0] w);
    stim_row_t s;
    s = '0;
    s.kind = kd; s.nbytes = b; s.lat = l; s.win = w;
    return s;
  endfunction

  initial begin
    stim_row_t s;
    kind_e kd;
    int r, burst;
    logic [31:0] b, l;
    wipe_history();

    // empty ring query: known all-zero result
    s = row(KIND_QUERY, '0, '0, 7'd0); s.known = 1'b1; directed.push_back(s);
    s = row(KIND_TICK, '0, '0, '0); directed.push_back(s);          // idle interval
    s = row(KIND_QUERY, '0, '0, 7'd1); s.known = 1'b1; s.sum.used = 7'd1;
    directed.push_back(s);
    directed.push_back(row(KIND_COMPLETE, 32'd0, 32'd0, 7'h7F));
    directed.push_back(row(KIND_COMPLETE, 32'd512, 32'd1, '0));
    directed.push_back(row(KIND_COMPLETE, 32'd513, 32'd2, '0));
    directed.push_back(row(KIND_COMPLETE, 32'd1024, 32'd3, '0));
    directed.push_back(row(KIND_COMPLETE, 32'd2048, 32'd4, '0));
    directed.push_back(row(KIND_COMPLETE, 32'd4096, 32'd5, '0));
    directed.push_back(row(KIND_COMPLETE, 32'd8192, 32'd6, '0));
    directed.push_back(row(KIND_COMPLETE, 32'd8193, 32'hFFFF_FFFF, '0));
    directed.push_back(row(KIND_COMPLETE, 32'hFFFF_FFFF, 32'd0, '0));
    directed.push_back(row(KIND_TICK, '0, '0, '0));
    directed.push_back(row(KIND_QUERY, '0, '0, 7'd64));
    directed.push_back(row(KIND_QUERY, '0, '0, 7'd65));             // above depth
    directed.push_back(row(KIND_QUERY, '0, '0, 7'd127));
    directed.push_back(row(KIND_QUERY, '0, '0, 7'd5));              // above filled
    for (int i = 0; i < 3; i++)                                     // average at its 32-bit top
      directed.push_back(row(KIND_COMPLETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
    directed.push_back(row(KIND_TICK, '0, '0, '0));
    directed.push_back(row(KIND_QUERY, '0, '0, 7'd1));
    directed.push_back(row(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F));
    s = row(KIND_QUERY, '0, '0, 7'd0); s.known = 1'b1; directed.push_back(s);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      s = directed[i];
      send_item(s.kind, s.nbytes, s.lat, s.win);
      if (s.known && s.sum !== pending_sums[$]) begin
        $error("directed row %0d: predicted sum differs from table", i);
        errors++;
      end
    end

    // random part: bursts of completions closed by ticks, queries and rare clears between
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) kd = KIND_COMPLETE;
      else if (r < 80) kd = KIND_TICK;
      else if (r < 98) kd = KIND_QUERY;
      else kd = KIND_CLEAR;
      case ($urandom_range(0, 3))
        0: b = $urandom_range(0, 8400);
        1: b = $urandom;
        2: b = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: b = 32'd512 << $urandom_range(0, 4);
      endcase
      l = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
      send_item(kd, b, l, 7'($urandom_range(0, 127)));
      if (i == RANDOM_ITEMS / 2) wait_drained();
      // a run of ticks fills and wraps the ring
      if (i == RANDOM_ITEMS / 4)
        for (burst = 0; burst < 70; burst++)
          send_item(KIND_TICK, $urandom, $urandom, 7'($urandom_range(0, 127)));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
